### sv/gjs_pkg.sv
// ----------------------------------------------------------------------------
// gjs_pkg
// Shared constants, payload types and command/status structs for the
// Gauss-Jordan solver.
// ----------------------------------------------------------------------------
package gjs_pkg;

  localparam int MAX_DIM    = 8;
  localparam int STORE_COLS = MAX_DIM + 1;
  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 4;
  localparam int DEPTH      = MAX_DIM * STORE_COLS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int THR_W      = 31;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;

  localparam logic [2:0] WSRC_INPUT = 3'd0;
  localparam logic [2:0] WSRC_RDATA = 3'd1;
  localparam logic [2:0] WSRC_A     = 3'd2;
  localparam logic [2:0] WSRC_QUOT  = 3'd3;
  localparam logic [2:0] WSRC_ELIM  = 3'd4;

  typedef struct packed {
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         column_index;
    logic signed [WORD_W-1:0] element_value;
    logic                     load_last;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]         unknown_index;
    logic signed [WORD_W-1:0] solution_value;
    logic                     singular;
    logic                     result_last;
  } result_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             we;
    logic [2:0]       wsrc;
    logic             cap_a;
    logic             cap_b;
    logic             cap_f;
    logic             pv_clr;
    logic             pv_cmp;
    logic             div_start;
    logic             mul_en;
    logic             out_cap;
    logic             out_zero;
  } cmd_t;

  typedef struct packed {
    logic greater;
    logic singular;
    logic div_done;
  } status_t;

  function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

### sv/gjs_div.sv
// ----------------------------------------------------------------------------
// gjs_div
// Iterative fixed-point divider: sat((a << FRAC_BITS) / p), truncating,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gjs_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [gjs_pkg::WORD_W-1:0]   dividend,
  input  logic signed [gjs_pkg::WORD_W-1:0]   divisor,
  output logic                                done,
  output logic signed [gjs_pkg::WORD_W-1:0]   quotient
);
  import gjs_pkg::*;

  localparam int DW    = WORD_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DW + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DW-1:0]     dvd;
  logic [DW-1:0]     q;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dsor;
  logic              neg;
  logic [WORD_W:0]   rem_sh;
  logic              qbit;

  assign rem_sh = {rem, dvd[DW-1]};
  assign qbit   = rem_sh >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {mag32(dividend), {FRAC_BITS{1'b0}}};
      dsor <= mag32(divisor);
      neg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      q   <= {q[DW-2:0], qbit};
      rem <= qbit ? WORD_W'(rem_sh - {1'b0, dsor}) : rem_sh[WORD_W-1:0];
    end
  end

  always_comb begin
    if (neg) begin
      if (q > DW'({1'b1, {(WORD_W-1){1'b0}}})) quotient = {1'b1, {(WORD_W-1){1'b0}}};
      else quotient = -$signed(q[WORD_W-1:0]);
    end else begin
      if (q > DW'({1'b0, {(WORD_W-1){1'b1}}})) quotient = {1'b0, {(WORD_W-1){1'b1}}};
      else quotient = $signed(q[WORD_W-1:0]);
    end
  end

endmodule

### sv/gjs_datapath.sv
// ----------------------------------------------------------------------------
// gjs_datapath
// Augmented matrix store, pivot register, multiply-subtract and divider,
// driven by one command word a cycle.
// ----------------------------------------------------------------------------
module gjs_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  gjs_pkg::cmd_t                       cmd,
  input  logic signed [gjs_pkg::WORD_W-1:0]   in_value,
  input  logic [gjs_pkg::THR_W-1:0]           threshold,
  output gjs_pkg::status_t                    status,
  output logic signed [gjs_pkg::WORD_W-1:0]   out_value
);
  import gjs_pkg::*;

  localparam int PW = 2 * WORD_W;
  localparam int TW = PW - FRAC_BITS;
  localparam int DFW = TW + 1;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0]        addr;
  logic signed [WORD_W-1:0] wdata;
  logic signed [WORD_W-1:0] a;
  logic signed [WORD_W-1:0] b;
  logic signed [WORD_W-1:0] f;
  logic signed [WORD_W-1:0] pv;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     prod_adj;
  logic signed [TW-1:0]     tq;
  logic signed [DFW-1:0]    diff;
  logic signed [WORD_W-1:0] elim;
  logic signed [WORD_W-1:0] quot;
  logic                     div_done;

  gjs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rdata),
    .divisor  (pv),
    .done     (div_done),
    .quotient (quot)
  );

  assign addr = ADDR_W'(cmd.row) * ADDR_W'(STORE_COLS) + ADDR_W'(cmd.col);

  assign prod_adj = prod + (prod[PW-1] ? PW'((1 << FRAC_BITS) - 1) : PW'(0));
  assign tq       = prod_adj[PW-1:FRAC_BITS];
  assign diff     = DFW'(a) - DFW'(tq);

  always_comb begin
    if (diff > DFW'(32'sh7fffffff)) elim = 32'sh7fffffff;
    else if (diff < -DFW'(33'sh080000000)) elim = 32'sh80000000;
    else elim = diff[WORD_W-1:0];
  end

  always_comb begin
    case (cmd.wsrc)
      WSRC_INPUT: wdata = in_value;
      WSRC_RDATA: wdata = rdata;
      WSRC_A:     wdata = a;
      WSRC_QUOT:  wdata = quot;
      WSRC_ELIM:  wdata = elim;
      default:    wdata = in_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) a <= rdata;
    if (cmd.cap_b) b <= rdata;
    if (cmd.cap_f) f <= rdata;
    if (cmd.mul_en) prod <= f * b;
    if (cmd.pv_clr) pv <= '0;
    else if (cmd.pv_cmp && status.greater) pv <= rdata;
    if (cmd.out_zero) out_value <= '0;
    else if (cmd.out_cap) out_value <= rdata;
  end

  assign status.greater  = mag32(rdata) > mag32(pv);
  assign status.singular = (pv == '0) || (mag32(pv) < {1'b0, threshold});
  assign status.div_done = div_done;

endmodule

### sv/gjs_ctrl.sv
// ----------------------------------------------------------------------------
// gjs_ctrl
// Sequencer for load, pivot search, row swap, normalisation, elimination
// and result emission.
// ----------------------------------------------------------------------------
module gjs_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  gjs_pkg::item_t                  item,
  input  logic [gjs_pkg::COL_W-1:0]       size_in_use,
  input  gjs_pkg::status_t                status,
  output logic                            busy,
  output gjs_pkg::cmd_t                   cmd,
  output logic                            out_valid,
  output logic [gjs_pkg::ROW_W-1:0]       out_index,
  output logic                            out_singular,
  output logic                            out_last
);
  import gjs_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_P_START = 5'd1;
  localparam logic [4:0] ST_P_ISSUE = 5'd2;
  localparam logic [4:0] ST_P_CMP   = 5'd3;
  localparam logic [4:0] ST_P_CHK   = 5'd4;
  localparam logic [4:0] ST_W_RK    = 5'd5;
  localparam logic [4:0] ST_W_RB    = 5'd6;
  localparam logic [4:0] ST_W_WK    = 5'd7;
  localparam logic [4:0] ST_W_WB    = 5'd8;
  localparam logic [4:0] ST_N_RD    = 5'd9;
  localparam logic [4:0] ST_N_DIV   = 5'd10;
  localparam logic [4:0] ST_N_WAIT  = 5'd11;
  localparam logic [4:0] ST_N_WR    = 5'd12;
  localparam logic [4:0] ST_E_ROW   = 5'd13;
  localparam logic [4:0] ST_E_F     = 5'd14;
  localparam logic [4:0] ST_E_F2    = 5'd15;
  localparam logic [4:0] ST_E_RK    = 5'd16;
  localparam logic [4:0] ST_E_RI    = 5'd17;
  localparam logic [4:0] ST_E_MUL   = 5'd18;
  localparam logic [4:0] ST_E_WR    = 5'd19;
  localparam logic [4:0] ST_O_RD    = 5'd20;
  localparam logic [4:0] ST_O_OUT   = 5'd21;
  localparam logic [4:0] ST_S_OUT   = 5'd22;

  logic [4:0]       state, state_next;
  logic [COL_W-1:0] k, k_next;
  logic [COL_W-1:0] i, i_next;
  logic [COL_W-1:0] j, j_next;
  logic [COL_W-1:0] best, best_next;
  logic [COL_W-1:0] n;
  logic             emit, emit_sing, emit_last;

  always_comb begin
    if (size_in_use == '0) n = COL_W'(1);
    else if (size_in_use > COL_W'(MAX_DIM)) n = COL_W'(MAX_DIM);
    else n = size_in_use;
  end

  assign busy = state != ST_IDLE;

  always_comb begin
    state_next = state;
    k_next     = k;
    i_next     = i;
    j_next     = j;
    best_next  = best;
    cmd        = '0;
    cmd.wsrc   = WSRC_INPUT;
    emit       = 1'b0;
    emit_sing  = 1'b0;
    emit_last  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.row = item.row_index;
        cmd.col = item.column_index;
        if (start) begin
          cmd.we = item.column_index < COL_W'(STORE_COLS);
          if (item.load_last) begin
            k_next     = '0;
            state_next = ST_P_START;
          end
        end
      end
      ST_P_START: begin
        cmd.pv_clr = 1'b1;
        i_next     = k;
        best_next  = k;
        state_next = ST_P_ISSUE;
      end
      ST_P_ISSUE: begin
        cmd.row    = i[ROW_W-1:0];
        cmd.col    = k;
        state_next = ST_P_CMP;
      end
      ST_P_CMP: begin
        cmd.pv_cmp = 1'b1;
        if (status.greater) best_next = i;
        if (i == n - 1'b1) state_next = ST_P_CHK;
        else begin
          i_next     = i + 1'b1;
          state_next = ST_P_ISSUE;
        end
      end
      ST_P_CHK: begin
        if (status.singular) begin
          k_next     = '0;
          state_next = ST_S_OUT;
        end else if (best != k) begin
          j_next     = '0;
          state_next = ST_W_RK;
        end else begin
          j_next     = k;
          state_next = ST_N_RD;
        end
      end
      ST_W_RK: begin
        cmd.row    = k[ROW_W-1:0];
        cmd.col    = j;
        state_next = ST_W_RB;
      end
      ST_W_RB: begin
        cmd.cap_a  = 1'b1;
        cmd.row    = best[ROW_W-1:0];
        cmd.col    = j;
        state_next = ST_W_WK;
      end
      ST_W_WK: begin
        cmd.row    = k[ROW_W-1:0];
        cmd.col    = j;
        cmd.we     = 1'b1;
        cmd.wsrc   = WSRC_RDATA;
        state_next = ST_W_WB;
      end
      ST_W_WB: begin
        cmd.row  = best[ROW_W-1:0];
        cmd.col  = j;
        cmd.we   = 1'b1;
        cmd.wsrc = WSRC_A;
        if (j == n) begin
          j_next     = k;
          state_next = ST_N_RD;
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_W_RK;
        end
      end
      ST_N_RD: begin
        cmd.row    = k[ROW_W-1:0];
        cmd.col    = j;
        state_next = ST_N_DIV;
      end
      ST_N_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_N_WAIT;
      end
      ST_N_WAIT: begin
        if (status.div_done) state_next = ST_N_WR;
      end
      ST_N_WR: begin
        cmd.row  = k[ROW_W-1:0];
        cmd.col  = j;
        cmd.we   = 1'b1;
        cmd.wsrc = WSRC_QUOT;
        if (j == n) begin
          i_next     = '0;
          state_next = ST_E_ROW;
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_N_RD;
        end
      end
      ST_E_ROW: begin
        if (i == n) begin
          if (k == n - 1'b1) begin
            k_next     = '0;
            i_next     = '0;
            state_next = ST_O_RD;
          end else begin
            k_next     = k + 1'b1;
            state_next = ST_P_START;
          end
        end else if (i == k) begin
          i_next = i + 1'b1;
        end else begin
          state_next = ST_E_F;
        end
      end
      ST_E_F: begin
        cmd.row    = i[ROW_W-1:0];
        cmd.col    = k;
        state_next = ST_E_F2;
      end
      ST_E_F2: begin
        cmd.cap_f  = 1'b1;
        j_next     = k;
        state_next = ST_E_RK;
      end
      ST_E_RK: begin
        cmd.row    = k[ROW_W-1:0];
        cmd.col    = j;
        state_next = ST_E_RI;
      end
      ST_E_RI: begin
        cmd.cap_b  = 1'b1;
        cmd.row    = i[ROW_W-1:0];
        cmd.col    = j;
        state_next = ST_E_MUL;
      end
      ST_E_MUL: begin
        cmd.cap_a  = 1'b1;
        cmd.mul_en = 1'b1;
        state_next = ST_E_WR;
      end
      ST_E_WR: begin
        cmd.row  = i[ROW_W-1:0];
        cmd.col  = j;
        cmd.we   = 1'b1;
        cmd.wsrc = WSRC_ELIM;
        if (j == n) begin
          i_next     = i + 1'b1;
          state_next = ST_E_ROW;
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_E_RK;
        end
      end
      ST_O_RD: begin
        cmd.row    = i[ROW_W-1:0];
        cmd.col    = n;
        state_next = ST_O_OUT;
      end
      ST_O_OUT: begin
        cmd.out_cap = 1'b1;
        emit        = 1'b1;
        emit_last   = i == n - 1'b1;
        if (i == n - 1'b1) state_next = ST_IDLE;
        else begin
          i_next     = i + 1'b1;
          state_next = ST_O_RD;
        end
      end
      ST_S_OUT: begin
        cmd.out_zero = 1'b1;
        emit         = 1'b1;
        emit_sing    = 1'b1;
        emit_last    = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      i         <= '0;
      j         <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      i         <= i_next;
      j         <= j_next;
      best      <= best_next;
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index    <= emit_sing ? '0 : i[ROW_W-1:0];
      out_singular <= emit_sing;
      out_last     <= emit_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && out_singular |-> out_last)
    else $error("singular beat without last flag");
  assert property (@(posedge clk) disable iff (rst) out_valid |=> !out_valid)
    else $error("back-to-back result beats");
  assert property (@(posedge clk) disable iff (rst) state == ST_IDLE |-> k == '0)
    else $error("pivot column not cleared when idle");
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> !status.div_done)
    else $error("divider finished too early");

endmodule

### sv/gauss_jordan_solver_top.sv
// ----------------------------------------------------------------------------
// gauss_jordan_solver_top
// Gauss-Jordan solver with partial pivoting, signed Q15.16 arithmetic.
// ----------------------------------------------------------------------------
// An element is taken whenever start is high and busy is low. The element
// flagged load_last starts the solve and busy stays high until the last
// result is issued. Every memory access goes through the single store port.
// Each column k runs pivot search, a row swap when needed, normalisation
// through the divider and elimination; the results follow the last column.
// Results appear on result for one cycle each, marked by result_valid, and
// beats are never back to back; the receiver cannot hold them off.
// Configuration writes are always ready and are meant for idle periods.
module gauss_jordan_solver_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  gjs_pkg::item_t                      item,
  output logic                                result_valid,
  output gjs_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gjs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data
);
  import gjs_pkg::*;

  logic [COL_W-1:0]         size_in_use;
  logic [THR_W-1:0]         threshold;
  cmd_t                     cmd;
  status_t                  status;
  logic signed [WORD_W-1:0] out_value;
  logic [ROW_W-1:0]         out_index;
  logic                     out_singular;
  logic                     out_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= COL_W'(MAX_DIM);
      threshold   <= THR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE:   size_in_use <= cfg_data[COL_W-1:0];
        REG_THRESH: threshold   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  gjs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .size_in_use  (size_in_use),
    .status       (status),
    .busy         (busy),
    .cmd          (cmd),
    .out_valid    (result_valid),
    .out_index    (out_index),
    .out_singular (out_singular),
    .out_last     (out_last)
  );

  gjs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_value  (item.element_value),
    .threshold (threshold),
    .status    (status),
    .out_value (out_value)
  );

  assign result.unknown_index  = out_index;
  assign result.solution_value = out_value;
  assign result.singular       = out_singular;
  assign result.result_last    = out_last;

endmodule
